[hdl/i2cm_pkg.sv]
// Types and constants shared by the I2C master byte engine.
package i2cm_pkg;

   // Command codes carried in the operation field
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_SHORT_DELAY = 1'b0;
   localparam logic CSR_LONG_DELAY  = 1'b1;

   localparam logic [7:0] SHORT_DELAY_RESET = 8'd2;
   localparam logic [7:0] LONG_DELAY_RESET  = 8'd5;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

   // Bus phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ST_HOLD1 = 4'd1,
      PH_ST_HOLD2 = 4'd2,
      PH_SP_HOLD1 = 4'd3,
      PH_SP_HOLD2 = 4'd4,
      PH_W_SETUP  = 4'd5,
      PH_W_HIGH   = 4'd6,
      PH_W_LOW    = 4'd7,
      PH_A_SETUP  = 4'd8,
      PH_A_HIGH   = 4'd9,
      PH_A_LOW    = 4'd10,
      PH_R_HIGH   = 4'd11,
      PH_R_LOW    = 4'd12,
      PH_K_SETUP  = 4'd13,
      PH_K_HIGH   = 4'd14
   } phase_type;

   // Command class decided by the front end
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_kind_type;

   // Classified request held in the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   write_byte;
      logic         send_nack;
      logic         sda_in;
   } req_item_type;

   // One result
   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       cmd_done;
      logic [7:0] read_byte;
      logic       nack_seen;
   } rsp_item_type;

endpackage

[hdl/i2cm_if.sv]
// Valid/ready channel interfaces for requests and results.
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [1:0] operation;
   logic [7:0] write_byte;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, cmd_valid, operation, write_byte, send_nack, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, operation, write_byte, send_nack, sda_in,
                   output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_drive;
   logic       sda_drive;
   logic       busy_res;
   logic       cmd_done;
   logic [7:0] read_byte;
   logic       nack_seen;

   modport source (output valid, scl_drive, sda_drive, busy_res, cmd_done, read_byte,
                   nack_seen, input ready);
   modport sink   (input valid, scl_drive, sda_drive, busy_res, cmd_done, read_byte,
                   nack_seen, output ready);
endinterface

[hdl/i2cm_front.sv]
// Request front end: classifies requests and holds them in a two-entry queue.
module i2cm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   cmd_valid,
   input  logic [1:0]             operation,
   input  logic [7:0]             write_byte,
   input  logic                   send_nack,
   input  logic                   sda_in,
   output logic                   q_valid,
   output i2cm_pkg::req_item_type q_item,
   input  logic                   q_pop
);
   import i2cm_pkg::*;

   req_item_type entry_ff [2];
   req_item_type class_item;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;

   // Classify the incoming request
   always_comb begin
      class_item.write_byte = write_byte;
      class_item.send_nack  = send_nack;
      class_item.sda_in     = sda_in;
      if (!cmd_valid) begin
         class_item.kind = CMD_NONE;
      end else begin
         case (operation)
            OP_START: class_item.kind = CMD_START;
            OP_WRITE: class_item.kind = CMD_WRITE;
            OP_READ:  class_item.kind = CMD_READ;
            OP_STOP:  class_item.kind = CMD_STOP;
            default:  class_item.kind = CMD_NONE;
         endcase
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Advance the queue pointers and fill level
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified request
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

[hdl/i2cm_back.sv]
// Bus engine: walks the I2C phases one tick per request and registers each result.
module i2cm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  i2cm_pkg::req_item_type q_item,
   output logic                   q_pop,
   input  logic                   csr_write_en,
   input  logic                   csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output i2cm_pkg::rsp_item_type rsp_item
);
   import i2cm_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [7:0]   short_ff, long_ff;
   logic [7:0]   delay_ff, delay_in;
   logic [3:0]   bit_ff, bit_in;
   logic [7:0]   shift_ff, shift_in;
   logic         ack_ff, ack_in;
   logic         scl_ff, scl_in;
   logic         sda_ff, sda_in_lvl;
   logic         nack_ff, nack_in;
   logic [7:0]   hold_ff, hold_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;

   logic         step, idle, take_cmd, fire, done;
   logic [7:0]   delay_dec, short_ticks, long_ticks;
   logic [3:0]   bit_inc;
   logic         more_bits;

   assign step        = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop       = step;
   assign idle        = (phase_ff == PH_IDLE);
   assign take_cmd    = step && idle && (q_item.kind != CMD_NONE);
   assign delay_dec   = (delay_ff != 8'd0) ? delay_ff - 8'd1 : 8'd0;
   assign fire        = step && !idle && (delay_dec == 8'd0);
   assign short_ticks = (short_ff == 8'd0) ? 8'd1 : short_ff;
   assign long_ticks  = (long_ff == 8'd0) ? 8'd1 : long_ff;
   assign bit_inc     = bit_ff + 4'd1;
   assign more_bits   = (bit_inc < BITS_PER_BYTE);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take_cmd) begin
         case (q_item.kind)
            CMD_START: phase_in = PH_ST_HOLD1;
            CMD_WRITE: phase_in = PH_W_SETUP;
            CMD_READ:  phase_in = PH_R_HIGH;
            CMD_STOP:  phase_in = PH_SP_HOLD1;
            default:   phase_in = PH_IDLE;
         endcase
      end else if (fire) begin
         case (phase_ff)
            PH_ST_HOLD1: phase_in = PH_ST_HOLD2;
            PH_SP_HOLD1: phase_in = PH_SP_HOLD2;
            PH_W_SETUP:  phase_in = PH_W_HIGH;
            PH_W_HIGH:   phase_in = PH_W_LOW;
            PH_W_LOW:    phase_in = more_bits ? PH_W_SETUP : PH_A_SETUP;
            PH_A_SETUP:  phase_in = PH_A_HIGH;
            PH_A_HIGH:   phase_in = PH_A_LOW;
            PH_R_HIGH:   phase_in = PH_R_LOW;
            PH_R_LOW:    phase_in = more_bits ? PH_R_HIGH : PH_K_SETUP;
            PH_K_SETUP:  phase_in = PH_K_HIGH;
            default:     phase_in = PH_IDLE;
         endcase
      end
   end

   // Line levels, counters and shift register
   always_comb begin
      delay_in   = (step && !idle) ? delay_dec : delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      nack_in    = nack_ff;
      hold_in    = hold_ff;
      done       = 1'b0;

      if (take_cmd) begin
         case (q_item.kind)
            CMD_START: begin
               sda_in_lvl = 1'b1;
               scl_in     = 1'b1;
            end
            CMD_WRITE: begin
               sda_in_lvl = q_item.write_byte[7];
               shift_in   = {q_item.write_byte[6:0], 1'b0};
               bit_in     = 4'd0;
            end
            CMD_READ: begin
               ack_in     = q_item.send_nack;
               shift_in   = 8'd0;
               bit_in     = 4'd0;
               sda_in_lvl = 1'b1;
               scl_in     = 1'b1;
            end
            CMD_STOP: begin
               sda_in_lvl = 1'b0;
               scl_in     = 1'b1;
            end
            default: begin
               sda_in_lvl = sda_ff;
            end
         endcase
      end else if (fire) begin
         case (phase_ff)
            PH_ST_HOLD1: sda_in_lvl = 1'b0;
            PH_ST_HOLD2: begin
               scl_in = 1'b0;
               done   = 1'b1;
            end
            PH_SP_HOLD1: sda_in_lvl = 1'b1;
            PH_SP_HOLD2: done = 1'b1;
            PH_W_SETUP:  scl_in = 1'b1;
            PH_W_HIGH:   scl_in = 1'b0;
            PH_W_LOW: begin
               bit_in = bit_inc;
               if (more_bits) begin
                  sda_in_lvl = shift_ff[7];
                  shift_in   = {shift_ff[6:0], 1'b0};
               end else begin
                  sda_in_lvl = 1'b1;
               end
            end
            PH_A_SETUP:  scl_in = 1'b1;
            PH_A_HIGH: begin
               nack_in = q_item.sda_in;
               scl_in  = 1'b0;
            end
            PH_A_LOW:    done = 1'b1;
            PH_R_HIGH: begin
               shift_in = {shift_ff[6:0], q_item.sda_in};
               scl_in   = 1'b0;
            end
            PH_R_LOW: begin
               bit_in = bit_inc;
               if (more_bits) begin
                  scl_in = 1'b1;
               end else begin
                  hold_in    = shift_ff;
                  sda_in_lvl = ack_ff;
               end
            end
            PH_K_SETUP:  scl_in = 1'b1;
            PH_K_HIGH: begin
               scl_in     = 1'b0;
               sda_in_lvl = ~ack_ff;
               done       = 1'b1;
            end
            default: begin
               done = 1'b0;
            end
         endcase
      end

      // Load the hold count for the phase being entered
      if ((take_cmd || fire) && (phase_in != PH_IDLE)) begin
         if (phase_in inside {PH_ST_HOLD1, PH_ST_HOLD2, PH_SP_HOLD1, PH_SP_HOLD2,
                              PH_W_HIGH, PH_K_HIGH}) begin
            delay_in = long_ticks;
         end else begin
            delay_in = short_ticks;
         end
      end
   end

   // Engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= 8'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         ack_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         nack_ff  <= 1'b0;
         hold_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         nack_ff  <= nack_in;
         hold_ff  <= hold_in;
      end
   end

   // Delay registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= SHORT_DELAY_RESET;
         long_ff  <= LONG_DELAY_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SHORT_DELAY: short_ff <= csr_wdata;
            CSR_LONG_DELAY:  long_ff  <= csr_wdata;
            default:         short_ff <= short_ff;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff.scl_drive <= scl_in;
         rsp_ff.sda_drive <= sda_in_lvl;
         rsp_ff.busy_res  <= (phase_in != PH_IDLE);
         rsp_ff.cmd_done  <= done;
         rsp_ff.read_byte <= hold_in;
         rsp_ff.nack_seen <= nack_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hdl/i2c_master_byte_engine.sv]
// Top level of the I2C master byte engine.
//
//   channel   direction  handshake                  carries
//   req_bus   in         valid/ready                one bus tick, optional command
//   rsp_bus   out        valid/ready                line drives and status per tick
//   csr_*     in         write enable, no wait      short_delay, long_delay
//
// One request per clock is sustained while results are taken; each request yields one
// result, registered by the two-entry request queue and then the result register.
// Reset is synchronous: phase idle, both lines released, delays 2 and 5 ticks.
// A stalled result holds the engine; the queue then fills and req_bus.ready drops.
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_bus,
   i2cm_rsp_if.source rsp_bus,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import i2cm_pkg::*;

   logic         q_valid;
   logic         q_pop;
   req_item_type q_item;
   rsp_item_type rsp_item;

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .cmd_valid  (req_bus.cmd_valid),
      .operation  (req_bus.operation),
      .write_byte (req_bus.write_byte),
      .send_nack  (req_bus.send_nack),
      .sda_in     (req_bus.sda_in),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   i2cm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_item     (rsp_item)
   );

   // Drive the result channel payload
   assign rsp_bus.scl_drive = rsp_item.scl_drive;
   assign rsp_bus.sda_drive = rsp_item.sda_drive;
   assign rsp_bus.busy_res  = rsp_item.busy_res;
   assign rsp_bus.cmd_done  = rsp_item.cmd_done;
   assign rsp_bus.read_byte = rsp_item.read_byte;
   assign rsp_bus.nack_seen = rsp_item.nack_seen;

endmodule

[hdl/i2cm_checker.sv]
// Port checker for the I2C master byte engine, bound to the top level.
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       busy_res,
   input logic       cmd_done,
   input logic [7:0] read_byte
);
   logic last_done_ff;

   // Remember whether the last delivered result completed a command
   always_ff @(posedge clock) begin
      if (reset) begin
         last_done_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         last_done_ff <= cmd_done;
      end
   end

   // No result straight after reset
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Completion leaves the engine free
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cmd_done |-> !busy_res)
      else $error("completion reported while busy");

   // Every hold lasts at least one tick, so completions never follow each other
   a_no_double_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_done_ff |-> !cmd_done)
      else $error("two completions in consecutive results");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(cmd_done))
      else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .busy_res  (rsp_bus.busy_res),
   .cmd_done  (rsp_bus.cmd_done),
   .read_byte (rsp_bus.read_byte)
);

[dv/i2c_master_byte_engine_test.sv]
// Self-checking testbench for the I2C master byte engine: bus ticks in, predicted line drives out.
module i2c_master_byte_engine_test;
   import i2cm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int RANDOM_TICKS   = 400;
   localparam int HOLDOFF_CYCLES = 80;

   // One bus tick as offered on the request channel
   typedef struct {
      logic       cmd_valid;
      logic [1:0] operation;
      logic [7:0] write_byte;
      logic       send_nack;
      logic       sda_in;
   } bus_tick_type;

   typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic       csr_index;
   logic [7:0] csr_wdata;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();

   i2c_master_byte_engine DUT (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predicted bus engine state and timing registers
   phase_type  ph;
   logic [7:0] dly;
   logic [3:0] bit_cnt;
   logic [7:0] shreg;
   logic       ack_sel;
   logic       scl_lv;
   logic       sda_lv;
   logic       nack_lv;
   logic [7:0] rd_hold;
   logic [7:0] short_cfg;
   logic [7:0] long_cfg;

   rsp_item_type drives_due[$];

   // Stimulus controls and run statistics
   sda_mode_type sda_mode;
   bit           steady;
   bit           busy_noise;
   int           rsp_holdoff;
   int           mismatches;
   int           ticks_sent;
   int           cmds_done;
   int           timing_sets;
   int           ops_issued[4];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Report one mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Load the delay counter from a timing register; zero counts as one tick
   function automatic void hold_short(input phase_type nxt);
      dly = (short_cfg == 8'd0) ? 8'd1 : short_cfg;
      ph  = nxt;
   endfunction

   function automatic void hold_long(input phase_type nxt);
      dly = (long_cfg == 8'd0) ? 8'd1 : long_cfg;
      ph  = nxt;
   endfunction

   // Put the next data bit on SDA, MSB first
   function automatic void present_bit();
      sda_lv = shreg[7];
      shreg  = {shreg[6:0], 1'b0};
      hold_short(PH_W_SETUP);
   endfunction

   // Advance the predicted engine by one tick and return the line drives it gives
   function automatic rsp_item_type bus_step(input bus_tick_type t);
      rsp_item_type r;
      logic         done;
      done = 1'b0;
      if (ph == PH_IDLE) begin
         if (t.cmd_valid) begin
            case (t.operation)
               OP_START: begin
                  sda_lv = 1'b1;
                  scl_lv = 1'b1;
                  hold_long(PH_ST_HOLD1);
               end
               OP_WRITE: begin
                  shreg   = t.write_byte;
                  bit_cnt = 4'd0;
                  present_bit();
               end
               OP_READ: begin
                  ack_sel = t.send_nack;
                  shreg   = 8'h00;
                  bit_cnt = 4'd0;
                  sda_lv  = 1'b1;
                  scl_lv  = 1'b1;
                  hold_short(PH_R_HIGH);
               end
               default: begin
                  sda_lv = 1'b0;
                  scl_lv = 1'b1;
                  hold_long(PH_SP_HOLD1);
               end
            endcase
         end
      end else begin
         if (dly != 8'd0) dly = dly - 8'd1;
         if (dly == 8'd0) begin
            case (ph)
               PH_ST_HOLD1: begin
                  sda_lv = 1'b0;
                  hold_long(PH_ST_HOLD2);
               end
               PH_ST_HOLD2: begin
                  scl_lv = 1'b0;
                  ph     = PH_IDLE;
                  done   = 1'b1;
               end
               PH_SP_HOLD1: begin
                  sda_lv = 1'b1;
                  hold_long(PH_SP_HOLD2);
               end
               PH_SP_HOLD2: begin
                  ph   = PH_IDLE;
                  done = 1'b1;
               end
               PH_W_SETUP: begin
                  scl_lv = 1'b1;
                  hold_long(PH_W_HIGH);
               end
               PH_W_HIGH: begin
                  scl_lv = 1'b0;
                  hold_short(PH_W_LOW);
               end
               PH_W_LOW: begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < BITS_PER_BYTE) begin
                     present_bit();
                  end else begin
                     sda_lv = 1'b1;
                     hold_short(PH_A_SETUP);
                  end
               end
               PH_A_SETUP: begin
                  scl_lv = 1'b1;
                  hold_short(PH_A_HIGH);
               end
               PH_A_HIGH: begin
                  nack_lv = t.sda_in;
                  scl_lv  = 1'b0;
                  hold_short(PH_A_LOW);
               end
               PH_A_LOW: begin
                  ph   = PH_IDLE;
                  done = 1'b1;
               end
               PH_R_HIGH: begin
                  shreg  = {shreg[6:0], t.sda_in};
                  scl_lv = 1'b0;
                  hold_short(PH_R_LOW);
               end
               PH_R_LOW: begin
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt < BITS_PER_BYTE) begin
                     scl_lv = 1'b1;
                     hold_short(PH_R_HIGH);
                  end else begin
                     rd_hold = shreg;
                     sda_lv  = ack_sel;
                     hold_short(PH_K_SETUP);
                  end
               end
               PH_K_SETUP: begin
                  scl_lv = 1'b1;
                  hold_long(PH_K_HIGH);
               end
               PH_K_HIGH: begin
                  scl_lv = 1'b0;
                  sda_lv = ~ack_sel;
                  ph     = PH_IDLE;
                  done   = 1'b1;
               end
               default: ph = PH_IDLE;
            endcase
         end
      end
      if (done) cmds_done++;
      r.scl_drive = scl_lv;
      r.sda_drive = sda_lv;
      r.busy_res  = (ph != PH_IDLE);
      r.cmd_done  = done;
      r.read_byte = rd_hold;
      r.nack_seen = nack_lv;
      return r;
   endfunction

   // Mostly no gap, mostly short gaps, a few long ones
   function automatic int pick_gap();
      if (steady || $urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Build one tick; SDA follows the current line mode
   function automatic bus_tick_type make_tick(input logic cmd, input logic [1:0] op,
                                              input logic [7:0] wbyte, input logic nack);
      bus_tick_type t;
      t.cmd_valid  = cmd;
      t.operation  = op;
      t.write_byte = wbyte;
      t.send_nack  = nack;
      case (sda_mode)
         SDA_LOW:  t.sda_in = 1'b0;
         SDA_HIGH: t.sda_in = 1'b1;
         default:  t.sda_in = 1'($urandom_range(0, 1));
      endcase
      return t;
   endfunction

   // Offer one request, wait for it to be taken, then record its expected result
   task automatic send_tick(input bus_tick_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd_valid  <= t.cmd_valid;
      req_bus.operation  <= t.operation;
      req_bus.write_byte <= t.write_byte;
      req_bus.send_nack  <= t.send_nack;
      req_bus.sda_in     <= t.sda_in;
      do @(posedge clock); while (!req_bus.ready);
      drives_due.push_back(bus_step(t));
      ticks_sent++;
   endtask

   // Ticks with no command and random fields otherwise
   task automatic idle_ticks(input int n);
      repeat (n) begin
         send_tick(make_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      end
   endtask

   // Tick until the predicted engine is idle; busy ticks may carry stray commands
   task automatic drain_phase();
      while (ph != PH_IDLE) begin
         send_tick(make_tick(busy_noise && $urandom_range(0, 2) == 0,
                             2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1))));
      end
   endtask

   // Issue one command and walk it to completion
   task automatic run_command(input logic [1:0] op, input logic [7:0] wbyte,
                              input logic nack);
      ops_issued[op]++;
      send_tick(make_tick(1'b1, op, wbyte, nack));
      drain_phase();
   endtask

   // Hold the sender until every expected result has come back
   task automatic quiesce();
      drain_phase();
      req_bus.valid <= 1'b0;
      while (drives_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both timing registers while the engine is idle
   task automatic set_timing(input logic [7:0] short_ticks, input logic [7:0] long_ticks);
      quiesce();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SHORT_DELAY;
      csr_wdata    <= short_ticks;
      @(posedge clock);
      csr_index    <= CSR_LONG_DELAY;
      csr_wdata    <= long_ticks;
      @(posedge clock);
      csr_write_en <= 1'b0;
      short_cfg = short_ticks;
      long_cfg  = long_ticks;
      timing_sets++;
   endtask

   // Lines must hold their reset levels on ticks with no command
   task automatic test_idle_hold();
      sda_mode = SDA_RANDOM;
      idle_ticks(4);
   endtask

   // Full transfer with reset timing, fixed and random acknowledge levels
   task automatic test_default_timing();
      sda_mode = SDA_LOW;
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'h00, 1'b0);
      sda_mode = SDA_HIGH;
      run_command(OP_WRITE, 8'hFF, 1'b0);
      sda_mode = SDA_RANDOM;
      run_command(OP_WRITE, 8'hA5, 1'b0);
      run_command(OP_READ, 8'h00, 1'b0);
      sda_mode = SDA_HIGH;
      run_command(OP_READ, 8'h00, 1'b1);
      sda_mode = SDA_LOW;
      run_command(OP_READ, 8'h00, 1'b0);
      idle_ticks(2);
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_STOP, 8'h00, 1'b0);
      idle_ticks(2);
   endtask

   // Shortest and zero timing values, then the longest clock-high hold
   task automatic test_delay_extremes();
      sda_mode = SDA_RANDOM;
      set_timing(8'd1, 8'd1);
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'h5A, 1'b0);
      run_command(OP_READ, 8'h00, 1'b1);
      run_command(OP_STOP, 8'h00, 1'b0);
      set_timing(8'd0, 8'd0);
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'h81, 1'b0);
      run_command(OP_STOP, 8'h00, 1'b0);
      set_timing(8'd1, 8'd255);
      run_command(OP_READ, 8'h00, 1'b1);
   endtask

   // Commands offered while busy must be dropped
   task automatic test_busy_commands();
      set_timing(8'd2, 8'd3);
      busy_noise = 1'b1;
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'hC3, 1'b0);
      run_command(OP_READ, 8'h00, 1'b1);
      run_command(OP_STOP, 8'h00, 1'b0);
      busy_noise = 1'b0;
   endtask

   // Stall results for a long stretch while requests keep coming
   task automatic test_result_backpressure();
      set_timing(8'd1, 8'd2);
      steady      = 1'b1;
      rsp_holdoff = HOLDOFF_CYCLES;
      run_command(OP_START, 8'h00, 1'b0);
      run_command(OP_WRITE, 8'h3C, 1'b0);
      run_command(OP_STOP, 8'h00, 1'b0);
      steady = 1'b0;
      quiesce();
   endtask

   // Mostly well-formed transfers with random content, some stray command sequences
   task automatic test_random_traffic();
      int start_ticks;
      int n_bytes;
      start_ticks = ticks_sent;
      sda_mode    = SDA_RANDOM;
      while (ticks_sent - start_ticks < RANDOM_TICKS) begin
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 5) == 0)
               set_timing(8'($urandom_range(0, 6)), 8'($urandom_range(0, 8)));
            else
               set_timing(8'($urandom_range(1, 2)), 8'($urandom_range(1, 3)));
         end
         steady     = ($urandom_range(0, 4) == 0);
         busy_noise = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 6) != 0) begin
            run_command(OP_START, 8'h00, 1'b0);
            n_bytes = $urandom_range(1, 3);
            repeat (n_bytes) begin
               idle_ticks($urandom_range(0, 2));
               if ($urandom_range(0, 1) != 0)
                  run_command(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0);
               else
                  run_command(OP_READ, 8'h00, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 3) == 0) begin
               run_command(OP_START, 8'h00, 1'b0);
               run_command(OP_READ, 8'h00, 1'b1);
            end
            run_command(OP_STOP, 8'h00, 1'b0);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               run_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            end
         end
         idle_ticks($urandom_range(0, 3));
      end
      steady     = 1'b0;
      busy_noise = 1'b0;
   endtask

   // Result receiver: random stalls plus a hold-off requested by a test
   initial begin : result_receiver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_holdoff > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_holdoff--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Compare each accepted result with the oldest expected line drives
   always @(posedge clock) begin : result_check
      rsp_item_type got;
      rsp_item_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.scl_drive = rsp_bus.scl_drive;
         got.sda_drive = rsp_bus.sda_drive;
         got.busy_res  = rsp_bus.busy_res;
         got.cmd_done  = rsp_bus.cmd_done;
         got.read_byte = rsp_bus.read_byte;
         got.nack_seen = rsp_bus.nack_seen;
         if (drives_due.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            due = drives_due.pop_front();
            if (got.scl_drive !== due.scl_drive)
               report_mismatch($sformatf("scl_drive %b, expected %b",
                                         got.scl_drive, due.scl_drive));
            if (got.sda_drive !== due.sda_drive)
               report_mismatch($sformatf("sda_drive %b, expected %b",
                                         got.sda_drive, due.sda_drive));
            if (got.busy_res !== due.busy_res)
               report_mismatch($sformatf("busy_res %b, expected %b",
                                         got.busy_res, due.busy_res));
            if (got.cmd_done !== due.cmd_done)
               report_mismatch($sformatf("cmd_done %b, expected %b",
                                         got.cmd_done, due.cmd_done));
            if (got.read_byte !== due.read_byte)
               report_mismatch($sformatf("read_byte %h, expected %h",
                                         got.read_byte, due.read_byte));
            if (got.nack_seen !== due.nack_seen)
               report_mismatch($sformatf("nack_seen %b, expected %b",
                                         got.nack_seen, due.nack_seen));
         end
      end
   end

   // Abort when neither channel moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, drives_due.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      // Drive every input and the predictor to reset values
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd_valid  = 1'b0;
      req_bus.operation  = OP_START;
      req_bus.write_byte = 8'h00;
      req_bus.send_nack  = 1'b0;
      req_bus.sda_in     = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = CSR_SHORT_DELAY;
      csr_wdata          = 8'h00;
      ph          = PH_IDLE;
      dly         = 8'd0;
      bit_cnt     = 4'd0;
      shreg       = 8'h00;
      ack_sel     = 1'b0;
      scl_lv      = 1'b1;
      sda_lv      = 1'b1;
      nack_lv     = 1'b0;
      rd_hold     = 8'h00;
      short_cfg   = SHORT_DELAY_RESET;
      long_cfg    = LONG_DELAY_RESET;
      sda_mode    = SDA_RANDOM;
      steady      = 1'b0;
      busy_noise  = 1'b0;
      rsp_holdoff = 0;
      mismatches  = 0;
      ticks_sent  = 0;
      cmds_done   = 0;
      timing_sets = 0;
      ops_issued  = '{default: 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_hold();
      test_default_timing();
      test_delay_extremes();
      test_busy_commands();
      test_result_backpressure();
      test_random_traffic();
      quiesce();

      if (drives_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", drives_due.size()));
      $display("Run covered %0d bus ticks and %0d completed commands over %0d timing settings",
               ticks_sent, cmds_done, timing_sets + 1);
      $display("Commands issued: %0d start, %0d write, %0d read, %0d stop; %0d mismatches",
               ops_issued[OP_START], ops_issued[OP_WRITE], ops_issued[OP_READ],
               ops_issued[OP_STOP], mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/i2cm_pkg.sv
hdl/i2cm_if.sv
hdl/i2cm_front.sv
hdl/i2cm_back.sv
hdl/i2c_master_byte_engine.sv
hdl/i2cm_checker.sv
dv/i2c_master_byte_engine_test.sv
